[rtl/vfv_pkg.sv]
`timescale 1ns / 1ps
package vfv_pkg;

	localparam int COUNT_W    = 13;
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic REG_AIR_CODE   = 1'b0;
	localparam logic REG_WATER_CODE = 1'b1;

	// read steps of a query: the block itself, then the six neighbors
	localparam logic [2:0] STEP_SELF  = 3'd0;
	localparam logic [2:0] STEP_PX    = 3'd1;
	localparam logic [2:0] STEP_NX    = 3'd2;
	localparam logic [2:0] STEP_PY    = 3'd3;
	localparam logic [2:0] STEP_NY    = 3'd4;
	localparam logic [2:0] STEP_PZ    = 3'd5;
	localparam logic [2:0] STEP_NZ    = 3'd6;
	localparam logic [2:0] STEP_LAST  = 3'd7;
	localparam logic [2:0] STEP_FACE0 = 3'd2;

	typedef struct packed {
		logic       operation;
		logic       in_chunk;
		logic [3:0] pos_x;
		logic [3:0] pos_y;
		logic [3:0] pos_z;
		logic [7:0] new_type;
		logic [5:0] nb_ok;
	} cmd_t;

	typedef struct packed {
		logic [7:0] stored_type;
		logic [5:0] face_mask;
		logic       is_solid;
		logic       any_solid;
	} res_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_WRITE,
		B_QUERY
	} back_state_t;

endpackage

[rtl/vfv_fifo.sv]
`timescale 1ns / 1ps
module vfv_fifo
	import vfv_pkg::*;
#(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0]    entries_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_PTR_W:0]   count_q;
	logic                  do_push;
	logic                  do_pop;

	assign full    = (count_q == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[rtl/vfv_front.sv]
`timescale 1ns / 1ps
module vfv_front
	import vfv_pkg::*;
#(
	parameter int SIZE_X = 16,
	parameter int SIZE_Y = 16,
	parameter int SIZE_Z = 16
) (
	input  logic       operation,
	input  logic [3:0] pos_x,
	input  logic [3:0] pos_y,
	input  logic [3:0] pos_z,
	input  logic [7:0] new_type,
	output cmd_t       cmd
);

	logic [6:0] x_ext, y_ext, z_ext;

	assign x_ext = {3'b000, pos_x};
	assign y_ext = {3'b000, pos_y};
	assign z_ext = {3'b000, pos_z};

	always_comb begin
		cmd.operation = operation;
		cmd.in_chunk  = (x_ext < 7'(SIZE_X)) && (y_ext < 7'(SIZE_Y)) && (z_ext < 7'(SIZE_Z));
		cmd.pos_x     = pos_x;
		cmd.pos_y     = pos_y;
		cmd.pos_z     = pos_z;
		cmd.new_type  = new_type;
		// neighbors past the chunk edge read as type 0
		cmd.nb_ok[0]  = (x_ext + 7'd1) < 7'(SIZE_X);
		cmd.nb_ok[1]  = (pos_x != 4'd0);
		cmd.nb_ok[2]  = (y_ext + 7'd1) < 7'(SIZE_Y);
		cmd.nb_ok[3]  = (pos_y != 4'd0);
		cmd.nb_ok[4]  = (z_ext + 7'd1) < 7'(SIZE_Z);
		cmd.nb_ok[5]  = (pos_z != 4'd0);
	end

endmodule

[rtl/vfv_back.sv]
`timescale 1ns / 1ps
module vfv_back
	import vfv_pkg::*;
#(
	parameter int SIZE_X = 16,
	parameter int SIZE_Y = 16,
	parameter int SIZE_Z = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] air_code,
	input  logic [7:0] water_code,
	input  cmd_t       cmd_in,
	input  logic       cmd_empty,
	output logic       cmd_pop,
	input  logic       res_full,
	output logic       res_push,
	output res_t       res,
	output logic       clearing
);

	localparam int XW    = $clog2(SIZE_X);
	localparam int YW    = $clog2(SIZE_Y);
	localparam int ZW    = $clog2(SIZE_Z);
	localparam int AW    = XW + YW + ZW;
	localparam int DEPTH = 1 << AW;

	back_state_t        state_q, state_d;
	cmd_t               cmd_q;
	cmd_t               src;
	logic [2:0]         step_q;
	logic [2:0]         issue_step;
	logic [2:0]         nb_idx;
	logic [7:0]         self_q;
	logic [4:0]         mask_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] count_dec;
	logic [COUNT_W-1:0] count_d;
	logic [AW-1:0]      clr_q;
	logic [AW-1:0]      addr;
	logic [4:0]         ax, ay, az;
	logic               mem_we;
	logic [7:0]         mem_wdata;
	logic [7:0]         rdata_q;
	logic [7:0]         nb_val;
	logic               face_open;
	logic               self_solid;
	logic [7:0]         mem_q [DEPTH];

	assign clearing = (state_q == B_CLEAR);

	// count bookkeeping against the old value read in the previous cycle
	always_comb begin
		count_dec = count_q;
		if (rdata_q != air_code && count_q != '0) begin
			count_dec = count_q - 1'b1;
		end
		count_d = count_dec;
		if (cmd_q.new_type != air_code && count_dec != COUNT_MAX) begin
			count_d = count_dec + 1'b1;
		end
	end

	assign nb_idx     = 3'(step_q - STEP_FACE0);
	assign nb_val     = cmd_q.nb_ok[nb_idx] ? rdata_q : 8'd0;
	assign self_solid = (self_q != air_code);
	assign face_open  = (nb_val == air_code) || (nb_val == water_code && self_q != water_code);

	// neighbor coordinates; out-of-chunk ones are never used
	always_comb begin
		ax = {1'b0, src.pos_x};
		ay = {1'b0, src.pos_y};
		az = {1'b0, src.pos_z};
		case (issue_step)
			STEP_PX: ax = {1'b0, src.pos_x} + 5'd1;
			STEP_NX: ax = {1'b0, src.pos_x} - 5'd1;
			STEP_PY: ay = {1'b0, src.pos_y} + 5'd1;
			STEP_NY: ay = {1'b0, src.pos_y} - 5'd1;
			STEP_PZ: az = {1'b0, src.pos_z} + 5'd1;
			STEP_NZ: az = {1'b0, src.pos_z} - 5'd1;
			default: ;
		endcase
		if (state_q == B_CLEAR) begin
			addr = clr_q;
		end else begin
			addr = {XW'(ax), YW'(ay), ZW'(az)};
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd_pop    = 1'b0;
		res_push   = 1'b0;
		res        = '0;
		mem_we     = 1'b0;
		mem_wdata  = 8'd0;
		src        = cmd_q;
		issue_step = STEP_SELF;
		case (state_q)
			B_CLEAR: begin
				mem_we = 1'b1;
				if (clr_q == {AW{1'b1}}) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				src = cmd_in;
				if (!cmd_empty && !res_full) begin
					cmd_pop = 1'b1;
					if (!cmd_in.in_chunk) begin
						res_push      = 1'b1;
						res.any_solid = (count_q != '0);
					end else if (cmd_in.operation == OP_WRITE) begin
						state_d = B_WRITE;
					end else begin
						state_d = B_QUERY;
					end
				end
			end
			B_WRITE: begin
				mem_we          = 1'b1;
				mem_wdata       = cmd_q.new_type;
				res_push        = 1'b1;
				res.stored_type = cmd_q.new_type;
				res.is_solid    = (cmd_q.new_type != air_code);
				res.any_solid   = (count_d != '0);
				state_d         = B_IDLE;
			end
			B_QUERY: begin
				issue_step = step_q;
				if (step_q == STEP_LAST) begin
					res_push        = 1'b1;
					res.stored_type = self_q;
					res.face_mask   = self_solid ? {face_open, mask_q} : 6'd0;
					res.is_solid    = self_solid;
					res.any_solid   = (count_q != '0);
					state_d         = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q   <= '0;
			count_q <= '0;
			step_q  <= STEP_SELF;
		end else begin
			state_q <= state_d;
			if (state_q == B_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == B_WRITE) begin
				count_q <= count_d;
			end
			if (cmd_pop) begin
				step_q <= STEP_PX;
			end else if (state_q == B_QUERY) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd_in;
		end
		if (state_q == B_QUERY && step_q == STEP_PX) begin
			self_q <= rdata_q;
		end
		if (state_q == B_QUERY && step_q >= STEP_FACE0 && step_q != STEP_LAST) begin
			mask_q[nb_idx] <= face_open;
		end
	end

	// single-port block store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[addr] <= mem_wdata;
		end else begin
			rdata_q <= mem_q[addr];
		end
	end

	a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_CLEAR) |-> !cmd_pop)
		else $error("command taken during clearing pass");

	a_write_only_when_owned: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == B_CLEAR || state_q == B_WRITE))
		else $error("store written outside clear or write");

	a_result_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full queue");

	a_write_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_WRITE) |=> (state_q == B_IDLE))
		else $error("write did not finish in one cycle");

	a_query_step_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_QUERY) |-> (step_q != STEP_SELF))
		else $error("query step out of range");

endmodule

[rtl/voxel_face_visibility_unit.sv]
`timescale 1ns / 1ps
// Voxel chunk store with face culling. After reset the block sweeps the whole store to zero,
// one entry a cycle (2^(clog2(SIZE_X)+clog2(SIZE_Y)+clog2(SIZE_Z)) entries, 4096 at 16x16x16),
// and holds full high until the sweep ends. Items then pass a classifier and a two-entry command
// queue to a back end built around one single-port store: a query makes seven reads (the block
// and its neighbors, one read a cycle) plus the final face check, a write reads the old type and
// writes the new one, and an item outside the chunk is answered from idle. Results wait in a
// two-entry result queue so the back end runs on while pop is low until it fills. The user must write
// air_code and water_code via cfg_we/cfg_index/cfg_data only while idle; it is not enforced.
module voxel_face_visibility_unit
	import vfv_pkg::*;
#(
	parameter int SIZE_X = 16,
	parameter int SIZE_Y = 16,
	parameter int SIZE_Z = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       operation,
	input  logic [3:0] pos_x,
	input  logic [3:0] pos_y,
	input  logic [3:0] pos_z,
	input  logic [7:0] new_type,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] stored_type,
	output logic [5:0] face_mask,
	output logic       is_solid,
	output logic       any_solid,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	logic [7:0] air_code_q;
	logic [7:0] water_code_q;
	cmd_t       cmd_new;
	cmd_t       cmd_head;
	logic       cmd_full;
	logic       cmd_empty;
	logic       cmd_pop;
	logic       clearing;
	logic       res_full;
	logic       res_push;
	res_t       res_new;
	res_t       res_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			air_code_q   <= 8'd0;
			water_code_q <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AIR_CODE:   air_code_q   <= cfg_data;
				REG_WATER_CODE: water_code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// hold off items while the store is being cleared
	assign full = cmd_full | clearing;

	vfv_front #(
		.SIZE_X(SIZE_X),
		.SIZE_Y(SIZE_Y),
		.SIZE_Z(SIZE_Z)
	) u_front (
		.operation(operation),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.new_type (new_type),
		.cmd      (cmd_new)
	);

	vfv_fifo #(
		.WIDTH($bits(cmd_t))
	) u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push & ~full),
		.wdata (cmd_new),
		.full  (cmd_full),
		.pop   (cmd_pop),
		.rdata (cmd_head),
		.empty (cmd_empty)
	);

	vfv_back #(
		.SIZE_X(SIZE_X),
		.SIZE_Y(SIZE_Y),
		.SIZE_Z(SIZE_Z)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.air_code  (air_code_q),
		.water_code(water_code_q),
		.cmd_in    (cmd_head),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_new),
		.clearing  (clearing)
	);

	vfv_fifo #(
		.WIDTH($bits(res_t))
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_new),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_head),
		.empty (empty)
	);

	assign stored_type = res_head.stored_type;
	assign face_mask   = res_head.face_mask;
	assign is_solid    = res_head.is_solid;
	assign any_solid   = res_head.any_solid;

endmodule
